[rtl/ifrt_pkg.sv]
package ifrt_pkg;

   localparam int CONTEXTS_DEF  = 16;
   localparam int BLOCKS        = 8192;
   localparam int WORD_BITS     = 64;
   localparam int WORDS_PER_CTX = BLOCKS / WORD_BITS;
   localparam int WORD_IDX_W    = $clog2(WORDS_PER_CTX);
   localparam int BIT_IDX_W     = $clog2(WORD_BITS);
   localparam int BLK_W         = $clog2(BLOCKS);
   localparam int RUN_W         = BLK_W + 1;
   localparam int LEN_W         = 16;
   localparam int CFG_W         = 16;
   localparam int CNT_W         = 16;
   localparam int CSR_IDX_W     = 2;
   localparam int QUEUE_DEPTH   = 2;
   localparam int QUEUE_PTR_W   = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W   = $clog2(QUEUE_DEPTH + 1);

   localparam logic [CFG_W-1:0] TIMEOUT_RST    = 16'd30;
   localparam logic [CFG_W-1:0] NCTX_LIMIT_RST = 16'd10;
   localparam logic [CFG_W-1:0] PKT_LIMIT_RST  = 16'd1000;
   localparam logic [CNT_W-1:0] COUNT_MAX      = 16'hFFFF;

   localparam logic [CSR_IDX_W-1:0] CSR_TIMEOUT    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_NCTX_LIMIT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PKT_LIMIT  = 2'd2;

   typedef enum logic [2:0] {
      VERDICT_PASS     = 3'd0,
      VERDICT_HELD     = 3'd1,
      VERDICT_COMPLETE = 3'd2,
      VERDICT_FULL     = 3'd3,
      VERDICT_RANGE    = 3'd4
   } verdict_type;

   typedef enum logic [1:0] {
      KIND_PASS,
      KIND_RANGE,
      KIND_FRAG
   } kind_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DECIDE,
      ST_ALLOC,
      ST_CLEAR,
      ST_LOAD,
      ST_EVAL,
      ST_MARK,
      ST_CHECK,
      ST_RUN_RD,
      ST_RUN_EVAL,
      ST_FINISH,
      ST_RESULT
   } eng_state_type;

   typedef struct packed {
      logic        is_ipv6;
      logic [63:0] src_hi;
      logic [63:0] src_lo;
      logic [63:0] dst_hi;
      logic [63:0] dst_lo;
      logic [7:0]  proto;
      logic [31:0] ident;
   } key_type;

   typedef struct packed {
      kind_type         kind;
      key_type          key;
      logic             more_frags;
      logic [BLK_W-1:0] first_blk;
      logic [BLK_W-1:0] last_blk;
      logic             has_blks;
      logic [LEN_W-1:0] end_pos;
      logic [31:0]      now;
   } item_type;

   typedef struct packed {
      logic [CFG_W-1:0] timeout;
      logic [CFG_W-1:0] nctx_limit;
      logic [CFG_W-1:0] pkt_limit;
   } cfg_type;

   typedef struct packed {
      key_type     key;
      logic [31:0] expire;
   } ctx_entry_type;

   typedef struct packed {
      logic             sent;
      logic             last_seen;
      logic [LEN_W-1:0] length;
      logic [RUN_W-1:0] run;
   } slot_state_type;

   // count of consecutive ones from bit 0
   function automatic logic [BIT_IDX_W:0] ones_run(input logic [WORD_BITS-1:0] w);
      logic [BIT_IDX_W:0] n;
      n = (BIT_IDX_W + 1)'(WORD_BITS);
      for (int i = WORD_BITS - 1; i >= 0; i--) begin
         if (!w[i]) n = (BIT_IDX_W + 1)'(i);
      end
      return n;
   endfunction

endpackage

[rtl/ifrt_if.sv]
interface ifrt_req_if;
   logic        valid;
   logic        ready;
   logic        is_ipv6;
   logic [63:0] src_addr_hi;
   logic [63:0] src_addr_lo;
   logic [63:0] dst_addr_hi;
   logic [63:0] dst_addr_lo;
   logic [7:0]  protocol;
   logic [31:0] frag_id;
   logic [12:0] frag_offset;
   logic        more_frags;
   logic [15:0] payload_len;
   logic [31:0] now_seconds;

   modport source (output valid, is_ipv6, src_addr_hi, src_addr_lo, dst_addr_hi,
                   dst_addr_lo, protocol, frag_id, frag_offset, more_frags,
                   payload_len, now_seconds, input ready);
   modport sink (input valid, is_ipv6, src_addr_hi, src_addr_lo, dst_addr_hi,
                 dst_addr_lo, protocol, frag_id, frag_offset, more_frags,
                 payload_len, now_seconds, output ready);
endinterface

interface ifrt_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  verdict;
   logic [3:0]  context_index;
   logic [15:0] total_len;

   modport source (output valid, verdict, context_index, total_len, input ready);
   modport sink (input valid, verdict, context_index, total_len, output ready);
endinterface

interface ifrt_csr_if;
   logic        valid;
   logic        ready;
   logic [1:0]  index;
   logic [15:0] data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

[rtl/ifrt_front.sv]
module ifrt_front (
   ifrt_req_if.sink           req_if,
   input  logic               q_full,
   output logic               q_push,
   output ifrt_pkg::item_type q_item
);

   logic [ifrt_pkg::LEN_W:0]   end_full;
   logic [ifrt_pkg::RUN_W-1:0] nblk;

   assign req_if.ready = !q_full;
   assign q_push       = req_if.valid && !q_full;

   always_comb begin
      end_full = {1'b0, req_if.frag_offset, 3'b000} + (ifrt_pkg::LEN_W + 1)'(req_if.payload_len);
      nblk     = ifrt_pkg::RUN_W'(((ifrt_pkg::LEN_W + 1)'(req_if.payload_len) + 17'd7) >> 3);

      if (!req_if.more_frags && req_if.frag_offset == '0) begin
         q_item.kind = ifrt_pkg::KIND_PASS;
      end else if (end_full[ifrt_pkg::LEN_W]) begin
         q_item.kind = ifrt_pkg::KIND_RANGE;
      end else begin
         q_item.kind = ifrt_pkg::KIND_FRAG;
      end

      q_item.key.is_ipv6 = req_if.is_ipv6;
      if (req_if.is_ipv6) begin
         q_item.key.src_hi = req_if.src_addr_hi;
         q_item.key.src_lo = req_if.src_addr_lo;
         q_item.key.dst_hi = req_if.dst_addr_hi;
         q_item.key.dst_lo = req_if.dst_addr_lo;
         q_item.key.proto  = '0;
         q_item.key.ident  = req_if.frag_id;
      end else begin
         q_item.key.src_hi = '0;
         q_item.key.src_lo = {32'd0, req_if.src_addr_lo[31:0]};
         q_item.key.dst_hi = '0;
         q_item.key.dst_lo = {32'd0, req_if.dst_addr_lo[31:0]};
         q_item.key.proto  = req_if.protocol;
         q_item.key.ident  = {16'd0, req_if.frag_id[15:0]};
      end

      q_item.more_frags = req_if.more_frags;
      q_item.first_blk  = req_if.frag_offset;
      q_item.last_blk   = ifrt_pkg::BLK_W'(ifrt_pkg::RUN_W'(req_if.frag_offset) + nblk - 14'd1);
      q_item.has_blks   = (req_if.payload_len != '0);
      q_item.end_pos    = end_full[ifrt_pkg::LEN_W-1:0];
      q_item.now        = req_if.now_seconds;
   end

endmodule

[rtl/ifrt_queue.sv]
module ifrt_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  ifrt_pkg::item_type push_item,
   output logic               full,
   input  logic               pop,
   output logic               empty,
   output ifrt_pkg::item_type head
);

   ifrt_pkg::item_type               entries_ff [ifrt_pkg::QUEUE_DEPTH];
   logic [ifrt_pkg::QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [ifrt_pkg::QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [ifrt_pkg::QUEUE_CNT_W-1:0] cnt_ff, cnt_in;

   assign full  = (cnt_ff == ifrt_pkg::QUEUE_CNT_W'(ifrt_pkg::QUEUE_DEPTH));
   assign empty = (cnt_ff == '0);
   assign head  = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == ifrt_pkg::QUEUE_PTR_W'(ifrt_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == ifrt_pkg::QUEUE_PTR_W'(ifrt_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + 1'b1;
      end
      cnt_in = cnt_ff + ifrt_pkg::QUEUE_CNT_W'(push) - ifrt_pkg::QUEUE_CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) entries_ff[wr_ptr_ff] <= push_item;
   end

endmodule

[rtl/ifrt_engine.sv]
module ifrt_engine #(
   parameter int CONTEXTS = ifrt_pkg::CONTEXTS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  ifrt_pkg::cfg_type  cfg,
   input  logic               q_empty,
   input  ifrt_pkg::item_type q_head,
   output logic               q_pop,
   ifrt_rsp_if.source         rsp_if
);

   localparam int IDX_W = (CONTEXTS > 1) ? $clog2(CONTEXTS) : 1;
   localparam int BM_AW = IDX_W + ifrt_pkg::WORD_IDX_W;
   localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(CONTEXTS - 1);
   localparam logic [ifrt_pkg::WORD_IDX_W-1:0] WORD_LAST =
      ifrt_pkg::WORD_IDX_W'(ifrt_pkg::WORDS_PER_CTX - 1);

   ifrt_pkg::eng_state_type state_ff, state_in;

   ifrt_pkg::item_type       cur_ff, cur_in;
   logic                     purge_ff, purge_in;
   logic [ifrt_pkg::CNT_W-1:0] pkt_cnt_ff, pkt_cnt_in;
   logic [ifrt_pkg::CNT_W-1:0] nctx_cnt_ff, nctx_cnt_in;
   logic                     vld_ff [CONTEXTS];
   logic                     vld_in [CONTEXTS];
   logic [IDX_W-1:0]         scan_idx_ff, scan_idx_in;
   logic                     issue_ff, issue_in;
   logic                     chk_vld_ff, chk_vld_in;
   logic [IDX_W-1:0]         chk_idx_ff, chk_idx_in;
   logic                     hit_ff, hit_in;
   logic                     free_ff, free_in;
   logic [IDX_W-1:0]         free_idx_ff, free_idx_in;
   logic [IDX_W-1:0]         slot_ff, slot_in;
   logic [ifrt_pkg::WORD_IDX_W-1:0] word_ff, word_in;
   ifrt_pkg::slot_state_type st_ff, st_in;
   ifrt_pkg::verdict_type    verdict_ff, verdict_in;
   logic [3:0]               idx_ff, idx_in;
   logic [ifrt_pkg::LEN_W-1:0] total_ff, total_in;
   logic                     rsp_vld_ff, rsp_vld_in;
   ifrt_pkg::verdict_type    rsp_verdict_ff, rsp_verdict_in;
   logic [3:0]               rsp_idx_ff, rsp_idx_in;
   logic [ifrt_pkg::LEN_W-1:0] rsp_total_ff, rsp_total_in;

   ifrt_pkg::ctx_entry_type  ctx_mem [CONTEXTS];
   ifrt_pkg::ctx_entry_type  ctx_rd_ff;
   logic                     ctx_we;
   ifrt_pkg::ctx_entry_type  ctx_wdata;

   ifrt_pkg::slot_state_type sst_mem [CONTEXTS];
   ifrt_pkg::slot_state_type sst_rd_ff;
   logic                     sst_we;
   ifrt_pkg::slot_state_type sst_wdata;

   logic [ifrt_pkg::WORD_BITS-1:0] bm_mem [CONTEXTS * ifrt_pkg::WORDS_PER_CTX];
   logic [ifrt_pkg::WORD_BITS-1:0] bm_rd_ff;
   logic                           bm_we;
   logic [BM_AW-1:0]               bm_waddr;
   logic [BM_AW-1:0]               bm_raddr;
   logic [ifrt_pkg::WORD_BITS-1:0] bm_be;
   logic [ifrt_pkg::WORD_BITS-1:0] bm_wdata;

   logic                             purge_now;
   logic                             live;
   logic                             expired;
   logic [ifrt_pkg::WORD_IDX_W-1:0]  first_word, last_word;
   logic [ifrt_pkg::BIT_IDX_W-1:0]   lo_bit, hi_bit, run_bit;
   logic [ifrt_pkg::WORD_BITS-1:0]   run_word;
   logic [ifrt_pkg::BIT_IDX_W:0]     run_ones;
   logic [ifrt_pkg::RUN_W-1:0]       run_new;
   logic                             run_at_end;
   logic [ifrt_pkg::RUN_W-1:0]       need;
   logic                             complete;

   assign purge_now  = (nctx_cnt_ff > cfg.nctx_limit) || (pkt_cnt_ff > cfg.pkt_limit);
   assign first_word = cur_ff.first_blk[ifrt_pkg::BLK_W-1:ifrt_pkg::BIT_IDX_W];
   assign last_word  = cur_ff.last_blk[ifrt_pkg::BLK_W-1:ifrt_pkg::BIT_IDX_W];
   assign lo_bit     = (word_ff == first_word) ? cur_ff.first_blk[ifrt_pkg::BIT_IDX_W-1:0] : '0;
   assign hi_bit     = (word_ff == last_word) ? cur_ff.last_blk[ifrt_pkg::BIT_IDX_W-1:0] : '1;
   assign run_bit    = st_ff.run[ifrt_pkg::BIT_IDX_W-1:0];
   assign run_word   = bm_rd_ff >> run_bit;
   assign run_ones   = ifrt_pkg::ones_run(run_word);
   assign run_new    = st_ff.run + ifrt_pkg::RUN_W'(run_ones);
   assign run_at_end = ((ifrt_pkg::BIT_IDX_W + 1)'(run_bit) + run_ones) ==
                       (ifrt_pkg::BIT_IDX_W + 1)'(ifrt_pkg::WORD_BITS);
   assign need       = ifrt_pkg::RUN_W'(((ifrt_pkg::LEN_W + 1)'(st_ff.length) + 17'd7) >> 3);
   assign complete   = st_ff.last_seen && (st_ff.run == need);
   assign expired    = purge_ff && vld_ff[chk_idx_ff] && (cur_ff.now > ctx_rd_ff.expire);
   assign live       = vld_ff[chk_idx_ff] && !expired;
   assign bm_raddr   = {slot_ff, st_ff.run[ifrt_pkg::BLK_W-1:ifrt_pkg::BIT_IDX_W]};

   assign rsp_if.valid         = rsp_vld_ff;
   assign rsp_if.verdict       = rsp_verdict_ff;
   assign rsp_if.context_index = rsp_idx_ff;
   assign rsp_if.total_len     = rsp_total_ff;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ifrt_pkg::ST_IDLE: begin
            if (!q_empty) begin
               state_in = (purge_now || q_head.kind == ifrt_pkg::KIND_FRAG) ?
                          ifrt_pkg::ST_SCAN : ifrt_pkg::ST_RESULT;
            end
         end
         ifrt_pkg::ST_SCAN: begin
            if (chk_vld_ff && chk_idx_ff == IDX_LAST) state_in = ifrt_pkg::ST_DECIDE;
         end
         ifrt_pkg::ST_DECIDE: begin
            if (cur_ff.kind != ifrt_pkg::KIND_FRAG) state_in = ifrt_pkg::ST_RESULT;
            else if (hit_ff)                        state_in = ifrt_pkg::ST_LOAD;
            else if (free_ff)                       state_in = ifrt_pkg::ST_ALLOC;
            else                                    state_in = ifrt_pkg::ST_RESULT;
         end
         ifrt_pkg::ST_ALLOC: state_in = ifrt_pkg::ST_CLEAR;
         ifrt_pkg::ST_CLEAR: begin
            if (word_ff == WORD_LAST) state_in = ifrt_pkg::ST_LOAD;
         end
         ifrt_pkg::ST_LOAD: state_in = ifrt_pkg::ST_EVAL;
         ifrt_pkg::ST_EVAL: begin
            if (sst_rd_ff.sent)       state_in = ifrt_pkg::ST_RESULT;
            else if (cur_ff.has_blks) state_in = ifrt_pkg::ST_MARK;
            else                      state_in = ifrt_pkg::ST_CHECK;
         end
         ifrt_pkg::ST_MARK: begin
            if (word_ff == last_word) state_in = ifrt_pkg::ST_CHECK;
         end
         ifrt_pkg::ST_CHECK: begin
            state_in = (!st_ff.last_seen || st_ff.run[ifrt_pkg::RUN_W-1]) ?
                       ifrt_pkg::ST_FINISH : ifrt_pkg::ST_RUN_RD;
         end
         ifrt_pkg::ST_RUN_RD: state_in = ifrt_pkg::ST_RUN_EVAL;
         ifrt_pkg::ST_RUN_EVAL: begin
            state_in = (run_at_end && !run_new[ifrt_pkg::RUN_W-1]) ?
                       ifrt_pkg::ST_RUN_RD : ifrt_pkg::ST_FINISH;
         end
         ifrt_pkg::ST_FINISH: state_in = ifrt_pkg::ST_RESULT;
         ifrt_pkg::ST_RESULT: begin
            if (!rsp_vld_ff || rsp_if.ready) state_in = ifrt_pkg::ST_IDLE;
         end
         default: state_in = ifrt_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      q_pop          = 1'b0;
      cur_in         = cur_ff;
      purge_in       = purge_ff;
      pkt_cnt_in     = pkt_cnt_ff;
      nctx_cnt_in    = nctx_cnt_ff;
      vld_in         = vld_ff;
      scan_idx_in    = scan_idx_ff;
      issue_in       = issue_ff;
      chk_vld_in     = 1'b0;
      chk_idx_in     = chk_idx_ff;
      hit_in         = hit_ff;
      free_in        = free_ff;
      free_idx_in    = free_idx_ff;
      slot_in        = slot_ff;
      word_in        = word_ff;
      st_in          = st_ff;
      verdict_in     = verdict_ff;
      idx_in         = idx_ff;
      total_in       = total_ff;
      rsp_vld_in     = rsp_vld_ff && !rsp_if.ready;
      rsp_verdict_in = rsp_verdict_ff;
      rsp_idx_in     = rsp_idx_ff;
      rsp_total_in   = rsp_total_ff;
      ctx_we         = 1'b0;
      ctx_wdata      = '{key: cur_ff.key, expire: cur_ff.now + 32'(cfg.timeout)};
      sst_we         = 1'b0;
      sst_wdata      = st_ff;
      bm_we          = 1'b0;
      bm_waddr       = {slot_ff, word_ff};
      bm_be          = '1;
      bm_wdata       = '0;

      case (state_ff)
         ifrt_pkg::ST_IDLE: begin
            if (!q_empty) begin
               q_pop       = 1'b1;
               cur_in      = q_head;
               purge_in    = purge_now;
               pkt_cnt_in  = purge_now ? ifrt_pkg::CNT_W'(1) :
                             (pkt_cnt_ff == ifrt_pkg::COUNT_MAX) ? pkt_cnt_ff :
                             pkt_cnt_ff + 1'b1;
               if (purge_now) nctx_cnt_in = '0;
               scan_idx_in = '0;
               issue_in    = 1'b1;
               hit_in      = 1'b0;
               free_in     = 1'b0;
               verdict_in  = (q_head.kind == ifrt_pkg::KIND_RANGE) ?
                             ifrt_pkg::VERDICT_RANGE : ifrt_pkg::VERDICT_PASS;
               idx_in      = '0;
               total_in    = '0;
            end
         end
         ifrt_pkg::ST_SCAN: begin
            chk_vld_in = issue_ff;
            chk_idx_in = scan_idx_ff;
            if (issue_ff) begin
               if (scan_idx_ff == IDX_LAST) issue_in = 1'b0;
               else                         scan_idx_in = scan_idx_ff + 1'b1;
            end
            if (chk_vld_ff) begin
               if (expired) vld_in[chk_idx_ff] = 1'b0;
               if (cur_ff.kind == ifrt_pkg::KIND_FRAG) begin
                  if (live && !hit_ff && ctx_rd_ff.key == cur_ff.key) begin
                     hit_in  = 1'b1;
                     slot_in = chk_idx_ff;
                  end
                  if (!live && !free_ff) begin
                     free_in     = 1'b1;
                     free_idx_in = chk_idx_ff;
                  end
               end
            end
         end
         ifrt_pkg::ST_DECIDE: begin
            if (cur_ff.kind == ifrt_pkg::KIND_FRAG) begin
               if (!hit_ff && free_ff) slot_in = free_idx_ff;
               else if (!hit_ff)       verdict_in = ifrt_pkg::VERDICT_FULL;
            end
         end
         ifrt_pkg::ST_ALLOC: begin
            ctx_we          = 1'b1;
            sst_we          = 1'b1;
            sst_wdata       = '0;
            vld_in[slot_ff] = 1'b1;
            nctx_cnt_in     = (nctx_cnt_ff == ifrt_pkg::COUNT_MAX) ? nctx_cnt_ff :
                              nctx_cnt_ff + 1'b1;
            word_in         = '0;
         end
         ifrt_pkg::ST_CLEAR: begin
            bm_we   = 1'b1;
            word_in = word_ff + 1'b1;
         end
         ifrt_pkg::ST_EVAL: begin
            idx_in     = 4'(slot_ff);
            verdict_in = ifrt_pkg::VERDICT_HELD;
            st_in      = sst_rd_ff;
            if (!cur_ff.more_frags && !sst_rd_ff.last_seen) begin
               st_in.length    = cur_ff.end_pos;
               st_in.last_seen = 1'b1;
            end
            word_in = first_word;
         end
         ifrt_pkg::ST_MARK: begin
            bm_we    = 1'b1;
            bm_wdata = '1;
            for (int b = 0; b < ifrt_pkg::WORD_BITS; b++) begin
               bm_be[b] = (ifrt_pkg::BIT_IDX_W'(b) >= lo_bit) &&
                          (ifrt_pkg::BIT_IDX_W'(b) <= hi_bit);
            end
            word_in = word_ff + 1'b1;
         end
         ifrt_pkg::ST_RUN_EVAL: begin
            st_in.run = run_new;
         end
         ifrt_pkg::ST_FINISH: begin
            sst_we         = 1'b1;
            sst_wdata.sent = complete;
            if (complete) begin
               verdict_in = ifrt_pkg::VERDICT_COMPLETE;
               total_in   = st_ff.length;
            end
         end
         ifrt_pkg::ST_RESULT: begin
            if (!rsp_vld_ff || rsp_if.ready) begin
               rsp_vld_in     = 1'b1;
               rsp_verdict_in = verdict_ff;
               rsp_idx_in     = idx_ff;
               rsp_total_in   = total_ff;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ifrt_pkg::ST_IDLE;
         pkt_cnt_ff  <= '0;
         nctx_cnt_ff <= '0;
         issue_ff    <= 1'b0;
         chk_vld_ff  <= 1'b0;
         hit_ff      <= 1'b0;
         free_ff     <= 1'b0;
         rsp_vld_ff  <= 1'b0;
         for (int i = 0; i < CONTEXTS; i++) vld_ff[i] <= 1'b0;
      end else begin
         state_ff    <= state_in;
         pkt_cnt_ff  <= pkt_cnt_in;
         nctx_cnt_ff <= nctx_cnt_in;
         issue_ff    <= issue_in;
         chk_vld_ff  <= chk_vld_in;
         hit_ff      <= hit_in;
         free_ff     <= free_in;
         rsp_vld_ff  <= rsp_vld_in;
         vld_ff      <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff         <= cur_in;
      purge_ff       <= purge_in;
      scan_idx_ff    <= scan_idx_in;
      chk_idx_ff     <= chk_idx_in;
      free_idx_ff    <= free_idx_in;
      slot_ff        <= slot_in;
      word_ff        <= word_in;
      st_ff          <= st_in;
      verdict_ff     <= verdict_in;
      idx_ff         <= idx_in;
      total_ff       <= total_in;
      rsp_verdict_ff <= rsp_verdict_in;
      rsp_idx_ff     <= rsp_idx_in;
      rsp_total_ff   <= rsp_total_in;
   end

   always_ff @(posedge clock) begin
      if (ctx_we) ctx_mem[slot_ff] <= ctx_wdata;
      ctx_rd_ff <= ctx_mem[scan_idx_ff];
   end

   always_ff @(posedge clock) begin
      if (sst_we) sst_mem[slot_ff] <= sst_wdata;
      sst_rd_ff <= sst_mem[slot_ff];
   end

   always_ff @(posedge clock) begin
      if (bm_we) begin
         for (int b = 0; b < ifrt_pkg::WORD_BITS; b++) begin
            if (bm_be[b]) bm_mem[bm_waddr][b] <= bm_wdata[b];
         end
      end
      bm_rd_ff <= bm_mem[bm_raddr];
   end

   a_alloc_free_slot: assert property (@(posedge clock) disable iff (reset)
      state_ff == ifrt_pkg::ST_ALLOC |-> !vld_ff[slot_ff])
      else $error("allocation into a live slot");

   a_mark_in_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == ifrt_pkg::ST_MARK |-> word_ff >= first_word && word_ff <= last_word)
      else $error("bitmap mark outside fragment");

   a_complete_len: assert property (@(posedge clock) disable iff (reset)
      rsp_vld_ff && rsp_verdict_ff == ifrt_pkg::VERDICT_COMPLETE |-> rsp_total_ff != '0)
      else $error("completion with zero length");

   a_run_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == ifrt_pkg::ST_RUN_EVAL |-> !st_ff.run[ifrt_pkg::RUN_W-1])
      else $error("prefix scan past end of bitmap");

endmodule

[rtl/ip_fragment_reassembly_tracker_top.sv]
// channel | dir | handshake     | payload
// req_if  | in  | valid/ready   | one fragment descriptor per item
// rsp_if  | out | valid/ready   | verdict, context_index, total_len
// csr_if  | in  | valid/ready   | index 0..2, 16-bit data (always ready)
//
// Pass-through and out-of-range items skip the table scan unless a purge is due.
// Fragments take a serial table scan and slot update, plus a write per bitmap word
// marked and a read and evaluation per bitmap word the completion prefix advances over.
// A new context first zeros its 128-word bitmap row.
// Reset is synchronous; no clearing pass is needed after it.
// A two-item queue and the output register let either side stall independently.
module ip_fragment_reassembly_tracker_top #(
   parameter int CONTEXTS = ifrt_pkg::CONTEXTS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   ifrt_req_if.sink   req_if,
   ifrt_rsp_if.source rsp_if,
   ifrt_csr_if.sink   csr_if
);

   ifrt_pkg::cfg_type  cfg_ff, cfg_in;
   logic               q_full, q_push, q_pop, q_empty;
   ifrt_pkg::item_type q_item, q_head;

   assign csr_if.ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_if.valid) begin
         case (csr_if.index)
            ifrt_pkg::CSR_TIMEOUT:    cfg_in.timeout    = csr_if.data;
            ifrt_pkg::CSR_NCTX_LIMIT: cfg_in.nctx_limit = csr_if.data;
            ifrt_pkg::CSR_PKT_LIMIT:  cfg_in.pkt_limit  = csr_if.data;
            default:                  cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{timeout:    ifrt_pkg::TIMEOUT_RST,
                     nctx_limit: ifrt_pkg::NCTX_LIMIT_RST,
                     pkt_limit:  ifrt_pkg::PKT_LIMIT_RST};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   ifrt_front u_front (
      .req_if (req_if),
      .q_full (q_full),
      .q_push (q_push),
      .q_item (q_item)
   );

   ifrt_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (q_item),
      .full      (q_full),
      .pop       (q_pop),
      .empty     (q_empty),
      .head      (q_head)
   );

   ifrt_engine #(
      .CONTEXTS (CONTEXTS)
   ) u_engine (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg_ff),
      .q_empty (q_empty),
      .q_head  (q_head),
      .q_pop   (q_pop),
      .rsp_if  (rsp_if)
   );

endmodule

[sim/tb_ip_fragment_reassembly_tracker_top.sv]
module tb_ip_fragment_reassembly_tracker_top;

   localparam int NCTX = 16;
   localparam int CYCLE_LIMIT = 3000000;

   typedef struct {
      logic        is_ipv6;
      logic [63:0] src_hi;
      logic [63:0] src_lo;
      logic [63:0] dst_hi;
      logic [63:0] dst_lo;
      logic [7:0]  proto;
      logic [31:0] ident;
      logic [12:0] offset;
      logic        mf;
      logic [15:0] plen;
      logic [31:0] now;
   } frag_desc_type;

   typedef struct {
      ifrt_pkg::verdict_type verdict;
      logic [3:0]  slot;
      logic [15:0] total;
   } verdict_rec_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   ifrt_req_if req_if ();
   ifrt_rsp_if rsp_if ();
   ifrt_csr_if csr_if ();

   ip_fragment_reassembly_tracker_top dut (
      .clock(clock), .reset(reset),
      .req_if(req_if), .rsp_if(rsp_if), .csr_if(csr_if)
   );

   always #5 clock = ~clock;

   // tracker state kept by the testbench
   logic [15:0] cfg_timeout, cfg_nctx_limit, cfg_pkt_limit;
   logic        c_valid[NCTX];
   logic        c_v6[NCTX];
   logic [63:0] c_shi[NCTX], c_slo[NCTX], c_dhi[NCTX], c_dlo[NCTX];
   logic [7:0]  c_proto[NCTX];
   logic [31:0] c_ident[NCTX], c_expire[NCTX];
   logic        c_sent[NCTX], c_last[NCTX];
   logic [15:0] c_len[NCTX];
   logic [8191:0] c_map[NCTX];
   int unsigned new_ctx_count, pkt_count;

   verdict_rec_type expected_verdicts[$];
   int  errors = 0;
   int  cycles = 0;
   bit  quiet_idle = 0;
   logic [31:0] clock_now;

   function automatic verdict_rec_type track_fragment(frag_desc_type d);
      verdict_rec_type r;
      int unsigned fin, nb, run;
      int slot;
      bit hit;
      logic [63:0] shi, slo, dhi, dlo;
      logic [7:0] pr;
      logic [31:0] id;
      r.verdict = ifrt_pkg::VERDICT_PASS; r.slot = '0; r.total = '0;
      if (new_ctx_count > cfg_nctx_limit || pkt_count > cfg_pkt_limit) begin
         for (int i = 0; i < NCTX; i++)
            if (c_valid[i] && d.now > c_expire[i]) c_valid[i] = 1'b0;
         new_ctx_count = 0;
         pkt_count = 0;
      end
      if (pkt_count < 65535) pkt_count++;
      if (!d.mf && d.offset == '0) return r;
      fin = d.offset * 8 + d.plen;
      if (fin > 65535) begin
         r.verdict = ifrt_pkg::VERDICT_RANGE;
         return r;
      end
      shi = d.src_hi; slo = d.src_lo; dhi = d.dst_hi; dlo = d.dst_lo;
      pr = d.proto; id = d.ident;
      if (!d.is_ipv6) begin
         shi = '0; dhi = '0; slo[63:32] = '0; dlo[63:32] = '0; id[31:16] = '0;
      end else pr = '0;
      hit = 1'b0; slot = 0;
      for (int i = 0; i < NCTX && !hit; i++)
         if (c_valid[i] && c_v6[i] == d.is_ipv6 && c_shi[i] == shi && c_slo[i] == slo &&
             c_dhi[i] == dhi && c_dlo[i] == dlo && c_proto[i] == pr && c_ident[i] == id) begin
            hit = 1'b1; slot = i;
         end
      if (!hit) begin
         for (int i = 0; i < NCTX && !hit; i++)
            if (!c_valid[i]) begin hit = 1'b1; slot = i; end
         if (!hit) begin
            r.verdict = ifrt_pkg::VERDICT_FULL;
            return r;
         end
         c_valid[slot] = 1'b1; c_v6[slot] = d.is_ipv6;
         c_shi[slot] = shi; c_slo[slot] = slo; c_dhi[slot] = dhi; c_dlo[slot] = dlo;
         c_proto[slot] = pr; c_ident[slot] = id;
         c_expire[slot] = d.now + 32'(cfg_timeout);
         c_sent[slot] = 1'b0; c_last[slot] = 1'b0; c_len[slot] = '0; c_map[slot] = '0;
         if (new_ctx_count < 65535) new_ctx_count++;
      end
      r.slot = 4'(slot);
      r.verdict = ifrt_pkg::VERDICT_HELD;
      if (c_sent[slot]) return r;
      if (!d.mf && !c_last[slot]) begin
         c_len[slot] = 16'(fin);
         c_last[slot] = 1'b1;
      end
      nb = (d.plen + 7) / 8;
      for (int unsigned i = 0; i < nb; i++)
         if (d.offset + i < 8192) c_map[slot][d.offset + i] = 1'b1;
      if (c_last[slot]) begin
         run = 0;
         while (run < 8192 && c_map[slot][run]) run++;
         if (run == (c_len[slot] + 7) / 8) begin
            c_sent[slot] = 1'b1;
            r.verdict = ifrt_pkg::VERDICT_COMPLETE;
            r.total = c_len[slot];
         end
      end
      return r;
   endfunction

   function automatic bit idle_now();
      return !quiet_idle && $urandom_range(99) < 6;
   endfunction

   task automatic send_fragment(frag_desc_type d);
      while (idle_now()) begin
         req_if.valid <= 1'b0;
         @(negedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.is_ipv6 <= d.is_ipv6;
      req_if.src_addr_hi <= d.src_hi;
      req_if.src_addr_lo <= d.src_lo;
      req_if.dst_addr_hi <= d.dst_hi;
      req_if.dst_addr_lo <= d.dst_lo;
      req_if.protocol <= d.proto;
      req_if.frag_id <= d.ident;
      req_if.frag_offset <= d.offset;
      req_if.more_frags <= d.mf;
      req_if.payload_len <= d.plen;
      req_if.now_seconds <= d.now;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      expected_verdicts.push_back(track_fragment(d));
      @(negedge clock);
   endtask

   task automatic write_csr(logic [1:0] idx, logic [15:0] val);
      csr_if.valid <= 1'b1;
      csr_if.index <= idx;
      csr_if.data <= val;
      @(posedge clock);
      while (!csr_if.ready) @(posedge clock);
      case (idx)
         ifrt_pkg::CSR_TIMEOUT: cfg_timeout = val;
         ifrt_pkg::CSR_NCTX_LIMIT: cfg_nctx_limit = val;
         default: cfg_pkt_limit = val;
      endcase
      @(negedge clock);
      csr_if.valid <= 1'b0;
      @(negedge clock);
   endtask

   task automatic drain();
      req_if.valid <= 1'b0;
      while (expected_verdicts.size() != 0) @(negedge clock);
      repeat (20) @(negedge clock);
   endtask

   function automatic frag_desc_type random_flow(int flow, bit v6);
      frag_desc_type d;
      d.is_ipv6 = v6;
      d.src_hi = v6 ? {$urandom, $urandom} : 64'h0;
      d.src_lo = {32'h0, 32'(32'h0a000000 + flow)};
      d.dst_hi = 64'h0;
      d.dst_lo = {32'h0, 32'hc0a80001};
      d.proto = 8'd17;
      d.ident = 32'(flow);
      d.offset = '0; d.mf = 1'b1; d.plen = 16'd8; d.now = clock_now;
      return d;
   endfunction

   function automatic frag_desc_type random_noise();
      frag_desc_type d;
      d.is_ipv6 = 1'($urandom);
      d.src_hi = {$urandom, $urandom}; d.src_lo = {$urandom, $urandom};
      d.dst_hi = {$urandom, $urandom}; d.dst_lo = {$urandom, $urandom};
      d.proto = 8'($urandom); d.ident = $urandom;
      d.offset = 13'($urandom); d.mf = 1'($urandom); d.plen = 16'($urandom);
      d.now = $urandom;
      return d;
   endfunction

   // send one datagram of 1..4 fragments in random order, some dropped or overlapped
   task automatic send_datagram(frag_desc_type base, bit broken);
      frag_desc_type parts[$];
      frag_desc_type d;
      int n, j;
      int unsigned off;
      n = $urandom_range(4, 1);
      off = 0;
      for (int i = 0; i < n; i++) begin
         d = base;
         d.offset = 13'(off);
         d.plen = (i == n - 1) ? 16'($urandom_range(40, 1)) : 16'(8 * $urandom_range(6, 1));
         d.mf = (i != n - 1);
         off += d.plen / 8;
         parts.push_back(d);
      end
      if (n == 1) parts[0].offset = 13'($urandom_range(3, 1));
      for (int i = 0; i < parts.size(); i++) begin
         j = $urandom_range(parts.size() - 1);
         d = parts[i]; parts[i] = parts[j]; parts[j] = d;
      end
      if (broken && parts.size() > 1) void'(parts.pop_front());
      if ($urandom_range(3) == 0) parts.push_back(parts[0]);
      foreach (parts[i]) begin
         parts[i].now = clock_now;
         send_fragment(parts[i]);
      end
   endtask

   task automatic test_edges();
      frag_desc_type d;
      d = random_flow(1, 1'b0);
      d.mf = 1'b0; d.offset = 13'd0; send_fragment(d);
      d.offset = 13'h1fff; d.plen = 16'hffff; send_fragment(d);
      d.offset = 13'h1fff; d.plen = 16'd8; send_fragment(d);
      d.offset = 13'h1fff; d.plen = 16'd7; send_fragment(d);
      d = random_flow(2, 1'b0); d.plen = 16'hffff; d.mf = 1'b1; send_fragment(d);
      d = random_flow(3, 1'b0); d.offset = 13'd0; d.plen = 16'd16; send_fragment(d);
      d.offset = 13'd2; d.mf = 1'b0; d.plen = 16'd5; send_fragment(d);
      d.offset = 13'd0; d.mf = 1'b1; send_fragment(d);
      d = random_flow(4, 1'b1);
      d.src_hi = '1; d.src_lo = '1; d.dst_hi = '1; d.dst_lo = '1;
      d.ident = '1; d.proto = '1; d.offset = 13'd1; d.mf = 1'b0; d.plen = 16'd0;
      send_fragment(d);
      d.offset = 13'd0; d.mf = 1'b1; d.plen = 16'd8; d.proto = 8'h00; send_fragment(d);
      d = random_flow(5, 1'b0); d.src_lo[63:32] = '1; d.ident[31:16] = '1; d.offset = 13'd0;
      d.plen = 16'd24; send_fragment(d);
      d.src_lo[63:32] = '0; d.ident[31:16] = '0; d.offset = 13'd3; d.mf = 1'b0;
      d.plen = 16'd8;
      send_fragment(d);
      d.offset = 13'd4; d.mf = 1'b0; d.plen = 16'd64; send_fragment(d);
      send_fragment(random_noise());
      drain();
   endtask

   task automatic test_table_full();
      frag_desc_type d;
      for (int i = 0; i < 18; i++) begin
         d = random_flow(100 + i, i[0]);
         d.plen = 16'd16;
         send_fragment(d);
      end
      drain();
   endtask

   task automatic test_purge_expiry();
      write_csr(ifrt_pkg::CSR_TIMEOUT, 16'd1);
      write_csr(ifrt_pkg::CSR_NCTX_LIMIT, 16'd0);
      write_csr(ifrt_pkg::CSR_PKT_LIMIT, 16'd0);
      clock_now = 32'hffff_fff0;
      for (int i = 0; i < 40; i++) begin
         clock_now += $urandom_range(2);
         send_datagram(random_flow(200 + i % 20, 1'b0), 1'b0);
      end
      drain();
      write_csr(ifrt_pkg::CSR_TIMEOUT, 16'hffff);
      write_csr(ifrt_pkg::CSR_NCTX_LIMIT, 16'hffff);
      write_csr(ifrt_pkg::CSR_PKT_LIMIT, 16'hffff);
      for (int i = 0; i < 20; i++) send_datagram(random_flow(300 + i, i[0]), 1'b1);
      drain();
   endtask

   task automatic test_random_traffic();
      int flow;
      for (int ph = 0; ph < 3; ph++) begin
         write_csr(ifrt_pkg::CSR_TIMEOUT, 16'($urandom_range(40, 2)));
         write_csr(ifrt_pkg::CSR_NCTX_LIMIT, 16'($urandom_range(20)));
         write_csr(ifrt_pkg::CSR_PKT_LIMIT, 16'($urandom_range(200, 5)));
         quiet_idle = (ph == 1);
         for (int i = 0; i < 110; i++) begin
            clock_now += $urandom_range(3);
            flow = $urandom_range(40);
            if ($urandom_range(9) == 0) send_fragment(random_noise());
            else send_datagram(random_flow(1000 * ph + flow, 1'($urandom)),
                               $urandom_range(7) == 0);
         end
         drain();
      end
      quiet_idle = 0;
   endtask

   always @(negedge clock) rsp_if.ready <= !idle_now();

   always @(posedge clock) begin
      verdict_rec_type e;
      cycles <= cycles + 1;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (expected_verdicts.size() == 0) begin
            $display("%0t: expected no item actual verdict %0d", $time, rsp_if.verdict);
            errors++;
         end else begin
            e = expected_verdicts.pop_front();
            if (rsp_if.verdict !== e.verdict || rsp_if.context_index !== e.slot ||
                rsp_if.total_len !== e.total) begin
               $display("%0t: expected %0d/%0d/%0d actual %0d/%0d/%0d", $time,
                        e.verdict, e.slot, e.total, rsp_if.verdict,
                        rsp_if.context_index, rsp_if.total_len);
               errors++;
            end
         end
      end
      if (cycles > CYCLE_LIMIT) begin
         $display("tb_ip_fragment_reassembly_tracker_top NOT OK");
         $finish;
      end
   end

   initial begin
      req_if.valid = 0; req_if.is_ipv6 = 0; req_if.src_addr_hi = 0; req_if.src_addr_lo = 0;
      req_if.dst_addr_hi = 0; req_if.dst_addr_lo = 0; req_if.protocol = 0; req_if.frag_id = 0;
      req_if.frag_offset = 0; req_if.more_frags = 0; req_if.payload_len = 0;
      req_if.now_seconds = 0;
      rsp_if.ready = 0;
      csr_if.valid = 0; csr_if.index = 0; csr_if.data = 0;
      cfg_timeout = ifrt_pkg::TIMEOUT_RST;
      cfg_nctx_limit = ifrt_pkg::NCTX_LIMIT_RST;
      cfg_pkt_limit = ifrt_pkg::PKT_LIMIT_RST;
      for (int i = 0; i < NCTX; i++) c_valid[i] = 1'b0;
      new_ctx_count = 0; pkt_count = 0; clock_now = 32'd100;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 0;
      test_edges();
      test_table_full();
      test_purge_expiry();
      test_random_traffic();
      drain();
      if (errors == 0 && expected_verdicts.size() == 0)
         $display("tb_ip_fragment_reassembly_tracker_top OK");
      else
         $display("tb_ip_fragment_reassembly_tracker_top NOT OK");
      $finish;
   end
endmodule

[sim.f]
rtl/ifrt_pkg.sv
rtl/ifrt_if.sv
rtl/ifrt_front.sv
rtl/ifrt_queue.sv
rtl/ifrt_engine.sv
rtl/ip_fragment_reassembly_tracker_top.sv
sim/tb_ip_fragment_reassembly_tracker_top.sv
